>>> rtl/core/ppq_pkg.sv
// Package: op codes, status codes and sequencer states for the process queue.
package ppq_pkg;
  typedef enum logic [2:0] {
    OP_INSERT      = 3'd0,
    OP_REMOVE_HEAD = 3'd1,
    OP_REMOVE_SLOT = 3'd2,
    OP_PEEK        = 3'd3,
    OP_QUERY       = 3'd4,
    OP_RSVD5       = 3'd5,
    OP_RSVD6       = 3'd6,
    OP_RSVD7       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_QUEUED  = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_WALK_RD, S_WALK_CMP, S_INS_RD, S_INS_W1, S_INS_W2, S_INS_W3,
    S_UNL_RD, S_UNL_W1, S_UNL_W2, S_DONE
  } fsm_e;
endpackage

>>> rtl/core/ppq_if.sv
// Valid/ready channel interfaces for request and response transactions.
interface ppq_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [2:0] queue_id;
  logic [4:0] proc_id;
  logic [7:0] priority_req;
  modport source (output valid, op, queue_id, proc_id, priority_req, input ready);
  modport sink   (input valid, op, queue_id, proc_id, priority_req, output ready);
endinterface

interface ppq_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] result_proc;
  logic       queue_empty;
  modport source (output valid, status, result_proc, queue_empty, input ready);
  modport sink   (input valid, status, result_proc, queue_empty, output ready);
endinterface

>>> rtl/core/ppq_slot_mem.sv
// Per-slot link and priority store: one write port, one registered read port.
module ppq_slot_mem #(
  parameter int unsigned AW = 5,
  parameter int unsigned DW = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> rtl/core/priority_process_queue_top.sv
// Top level: sequenced sorted linked-list priority queues over a slot pool.
// Usage:
//   req channel carries op, queue_id, proc_id, priority_req; rsp channel
//   returns status, result_proc, queue_empty, one response per request.
//   The block takes one request at a time; ready is low while it works.
// Sequencing:
//   peek, query, unused ops and every miss or error go from decode straight
//   to the response. Insert walks past every entry whose priority is >= the
//   new one and links the new slot at the tail or in front of the first
//   lower entry; each walk step is one read of the shared link store and
//   one priority compare.
// Reset:
//   all queues empty and every slot free; link and priority stores are
//   not cleared (only read behind a valid head or link).
// Stall:
//   the response sits in an output register until taken; the next request
//   is accepted in the cycle after the response is taken.
module priority_process_queue_top
  import ppq_pkg::*;
#(
  parameter int unsigned MAX_PROCS  = 32,
  parameter int unsigned NUM_QUEUES = 8,
  parameter int unsigned PRIO_BITS  = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  ppq_req_if.sink   req_i,
  ppq_rsp_if.source rsp_o
);
  localparam int unsigned SW = $clog2(MAX_PROCS);
  localparam int unsigned LW = SW + 1;
  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned DW = 2 * LW + PRIO_BITS;
  localparam logic [LW-1:0] NIL = '1;

  fsm_e state_q, state_d;
  logic [2:0] op_q;
  logic [QW-1:0] q_q;
  logic [SW-1:0] s_q;
  logic [PRIO_BITS-1:0] prio_q;
  logic [LW-1:0] cur_q, cur_d, nx_q, pv_q, nx_d, pv_d;
  logic [SW:0] guard_q, guard_d;
  logic [1:0] st_q, st_d;
  logic [4:0] res_q, res_d;
  logic emp_q, emp_d, rv_q;
  logic [LW-1:0] head_q [NUM_QUEUES];
  logic [LW-1:0] tail_q [NUM_QUEUES];
  logic [LW-1:0] head_d [NUM_QUEUES];
  logic [LW-1:0] tail_d [NUM_QUEUES];
  logic [MAX_PROCS-1:0] inq_q, inq_d;
  logic [QW-1:0] sq_q [MAX_PROCS];
  logic sq_we;

  logic we;
  logic [SW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [LW-1:0] rd_nx, rd_pv;
  logic [PRIO_BITS-1:0] rd_pr;
  logic q_ok, s_ok;
  logic [7:0] qx;
  logic [7:0] sx;

  assign rd_nx = rdata[DW-1 -: LW];
  assign rd_pv = rdata[DW-LW-1 -: LW];
  assign rd_pr = rdata[PRIO_BITS-1:0];

  ppq_slot_mem #(.AW(SW), .DW(DW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign req_i.ready = (state_q == S_IDLE) && !rv_q;
  assign rsp_o.valid = rv_q;
  assign rsp_o.status = st_q;
  assign rsp_o.result_proc = res_q;
  assign rsp_o.queue_empty = emp_q;

  assign qx = 8'(req_i.queue_id);
  assign sx = 8'(req_i.proc_id);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rv_q <= 1'b0;
      inq_q <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
      end
    end else begin
      state_q <= state_d;
      inq_q <= inq_d;
      head_q <= head_d;
      tail_q <= tail_d;
      if (state_q == S_DONE) rv_q <= 1'b1;
      else if (rsp_o.ready) rv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      op_q <= req_i.op;
      q_q <= QW'(req_i.queue_id);
      s_q <= SW'(req_i.proc_id);
      prio_q <= PRIO_BITS'(req_i.priority_req);
      q_ok <= qx < 8'(NUM_QUEUES);
      s_ok <= sx < 8'(MAX_PROCS);
    end
    if (sq_we) sq_q[s_q] <= q_q;
    cur_q <= cur_d;
    nx_q <= nx_d;
    pv_q <= pv_d;
    guard_q <= guard_d;
    st_q <= st_d;
    res_q <= res_d;
    emp_q <= emp_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_i.valid && req_i.ready) state_d = S_DEC;
      S_DEC: begin
        state_d = S_DONE;
        if (q_ok) begin
          if (op_q == OP_INSERT && s_ok && !inq_q[s_q])
            state_d = (head_q[q_q] == NIL) ? S_INS_W1 : S_WALK_RD;
          else if (op_q == OP_REMOVE_HEAD && head_q[q_q] != NIL) state_d = S_UNL_RD;
          else if (op_q == OP_REMOVE_SLOT && s_ok && inq_q[s_q] && sq_q[s_q] == q_q)
            state_d = S_UNL_RD;
        end
      end
      S_WALK_RD: state_d = S_WALK_CMP;
      S_WALK_CMP: begin
        if (rd_pr >= prio_q && guard_q < (SW+1)'(MAX_PROCS - 1)) begin
          state_d = (rd_nx == NIL) ? S_INS_W1 : S_WALK_RD;
        end else state_d = S_INS_RD;
      end
      S_INS_RD: state_d = S_INS_W1;
      S_INS_W1: state_d = S_INS_W2;
      S_INS_W2: state_d = S_INS_W3;
      S_INS_W3: state_d = S_DONE;
      S_UNL_RD: state_d = S_UNL_W1;
      S_UNL_W1: state_d = S_UNL_W2;
      S_UNL_W2: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath / outputs. cur_q = walk pointer (NIL means insert at tail).
  always_comb begin
    cur_d = cur_q; nx_d = nx_q; pv_d = pv_q; guard_d = guard_q;
    st_d = st_q; res_d = res_q; emp_d = emp_q;
    head_d = head_q; tail_d = tail_q; inq_d = inq_q; sq_we = 1'b0;
    we = 1'b0; waddr = s_q; wdata = '0; raddr = s_q;
    unique case (state_q)
      S_DEC: begin
        st_d = ST_OK; res_d = '0; guard_d = '0;
        cur_d = NIL; pv_d = tail_q[q_q]; nx_d = NIL;
        raddr = head_q[q_q][SW-1:0];
        if (!q_ok) begin
          st_d = (op_q <= OP_QUERY) ? ST_MISS : ST_OK;
        end else begin
          unique case (op_q)
            OP_INSERT: begin
              if (!s_ok) st_d = ST_MISS;
              else if (inq_q[s_q]) st_d = ST_QUEUED;
              else begin
                res_d = 5'(s_q);
                cur_d = head_q[q_q];
              end
            end
            OP_REMOVE_HEAD: begin
              if (head_q[q_q] == NIL) st_d = ST_MISS;
              else begin
                res_d = 5'(head_q[q_q]);
                cur_d = head_q[q_q];
              end
            end
            OP_REMOVE_SLOT: begin
              // links of the named slot are needed in the unlink read state
              raddr = s_q;
              if (!s_ok || !inq_q[s_q] || sq_q[s_q] != q_q) st_d = ST_MISS;
              else begin
                res_d = 5'(s_q);
                cur_d = LW'(s_q);
              end
            end
            OP_PEEK: begin
              if (head_q[q_q] == NIL) st_d = ST_MISS;
              else res_d = 5'(head_q[q_q]);
            end
            default: ;
          endcase
        end
      end
      S_WALK_RD: raddr = cur_q[SW-1:0];
      S_WALK_CMP: begin
        raddr = cur_q[SW-1:0];
        if (rd_pr >= prio_q && guard_q < (SW+1)'(MAX_PROCS - 1)) begin
          guard_d = guard_q + 1'b1;
          cur_d = rd_nx;
          if (rd_nx == NIL) pv_d = tail_q[q_q];
        end
      end
      S_INS_RD: begin
        raddr = cur_q[SW-1:0];
        pv_d = rd_pv;
      end
      S_INS_W1: begin
        // new slot: next, prev, priority
        we = 1'b1; waddr = s_q;
        wdata = {cur_q, pv_q, prio_q};
        inq_d[s_q] = 1'b1; sq_we = 1'b1;
        if (pv_q == NIL) head_d[q_q] = LW'(s_q);
        if (cur_q == NIL) tail_d[q_q] = LW'(s_q);
        raddr = pv_q[SW-1:0];
      end
      S_INS_W2: begin
        // fix predecessor's next
        raddr = cur_q[SW-1:0];
        if (pv_q != NIL) begin
          we = 1'b1; waddr = pv_q[SW-1:0];
          wdata = {LW'(s_q), rdata[DW-LW-1:0]};
        end
      end
      S_INS_W3: begin
        // fix successor's prev
        if (cur_q != NIL) begin
          we = 1'b1; waddr = cur_q[SW-1:0];
          wdata = {rdata[DW-1 -: LW], LW'(s_q), rdata[PRIO_BITS-1:0]};
        end
        emp_d = 1'b0;
      end
      S_UNL_RD: begin
        raddr = cur_q[SW-1:0];
        nx_d = rd_nx; pv_d = rd_pv;
        inq_d[cur_q[SW-1:0]] = 1'b0;
        raddr = rd_pv[SW-1:0];
        if (rd_pv == NIL) head_d[q_q] = rd_nx;
        if (rd_nx == NIL) tail_d[q_q] = rd_pv;
      end
      S_UNL_W1: begin
        raddr = nx_q[SW-1:0];
        if (pv_q != NIL) begin
          we = 1'b1; waddr = pv_q[SW-1:0];
          wdata = {nx_q, rdata[DW-LW-1:0]};
        end
      end
      S_UNL_W2: begin
        if (nx_q != NIL) begin
          we = 1'b1; waddr = nx_q[SW-1:0];
          wdata = {rdata[DW-1 -: LW], pv_q, rdata[PRIO_BITS-1:0]};
        end
        emp_d = (head_q[q_q] == NIL);
      end
      S_DONE: begin
        if (!q_ok) emp_d = 1'b1;
        else if (state_q == S_DONE && !(op_q == OP_INSERT && st_q == ST_OK))
          emp_d = (head_q[q_q] == NIL);
      end
      default: ;
    endcase
  end
endmodule

>>> tb/tb_priority_process_queue_top.sv
// Testbench for the priority process queue: directed table, then random traffic.
module tb_priority_process_queue_top;
  import ppq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPROC = 32;
  localparam int NQ = 8;
  localparam logic [5:0] NIL = 6'h3f;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    op_e        op;
    logic [2:0] qid;
    logic [4:0] pid;
    logic [7:0] prio;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [4:0] proc_id;
    logic       empty;
  } rsp_t;

  typedef struct {
    req_t req;
    logic has_rsp;
    rsp_t rsp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  ppq_req_if req_if ();
  ppq_rsp_if rsp_if ();

  priority_process_queue_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  // shadow of the queue state
  logic [5:0] nxt_q[NPROC];
  logic [5:0] prv_q[NPROC];
  logic [7:0] prio_q[NPROC];
  logic [3:0] owner_q[NPROC];
  logic [5:0] head_q[NQ];
  logic [5:0] tail_q[NQ];

  rsp_t pending_rsps[$];
  int   fails = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   wdog = 0;

  function automatic void unlink(int q, int s);
    logic [5:0] nx, pv;
    nx = nxt_q[s];
    pv = prv_q[s];
    if (pv == NIL) head_q[q] = nx; else nxt_q[pv] = nx;
    if (nx == NIL) tail_q[q] = pv; else prv_q[nx] = pv;
    owner_q[s] = 4'(NQ);
  endfunction

  function automatic void link_sorted(int q, int s, logic [7:0] p);
    logic [5:0] cur, pv;
    cur = head_q[q];
    while (cur != NIL && prio_q[cur] >= p) cur = nxt_q[cur];
    prio_q[s] = p;
    owner_q[s] = 4'(q);
    if (cur == NIL) begin
      prv_q[s] = tail_q[q];
      nxt_q[s] = NIL;
      if (tail_q[q] == NIL) head_q[q] = 6'(s); else nxt_q[tail_q[q]] = 6'(s);
      tail_q[q] = 6'(s);
    end else begin
      pv = prv_q[cur];
      prv_q[s] = pv;
      nxt_q[s] = cur;
      prv_q[cur] = 6'(s);
      if (pv == NIL) head_q[q] = 6'(s); else nxt_q[pv] = 6'(s);
    end
  endfunction

  function automatic rsp_t queue_step(req_t r);
    rsp_t o;
    int q, s;
    q = r.qid;
    s = r.pid;
    o = '{status: ST_OK, proc_id: '0, empty: 1'b0};
    case (r.op)
      OP_INSERT: begin
        if (owner_q[s] != 4'(NQ)) o.status = ST_QUEUED;
        else begin
          link_sorted(q, s, r.prio);
          o.proc_id = 5'(s);
        end
      end
      OP_REMOVE_HEAD: begin
        if (head_q[q] == NIL) o.status = ST_MISS;
        else begin
          o.proc_id = head_q[q][4:0];
          unlink(q, head_q[q]);
        end
      end
      OP_REMOVE_SLOT: begin
        if (owner_q[s] != 4'(q)) o.status = ST_MISS;
        else begin
          unlink(q, s);
          o.proc_id = 5'(s);
        end
      end
      OP_PEEK: begin
        if (head_q[q] == NIL) o.status = ST_MISS;
        else o.proc_id = head_q[q][4:0];
      end
      default: ;
    endcase
    o.empty = (head_q[q] == NIL);
    return o;
  endfunction

  function automatic row_t mk(op_e op, int q, int s, int p, logic chk = 0,
                              status_e st = ST_OK, int rp = 0, logic e = 0);
    row_t r;
    r.req = '{op: op, qid: 3'(q), pid: 5'(s), prio: 8'(p)};
    r.has_rsp = chk;
    r.rsp = '{status: st, proc_id: 5'(rp), empty: e};
    return r;
  endfunction

  // valid stays high between back-to-back sends; drain() drops it
  task automatic send(req_t r, logic has_rsp, rsp_t exp_rsp);
    rsp_t pred;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.op <= r.op;
    req_if.queue_id <= r.qid;
    req_if.proc_id <= r.pid;
    req_if.priority_req <= r.prio;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = queue_step(r);
    if (has_rsp && pred != exp_rsp) begin
      $error("table row disagrees with predictor: %p vs %p", exp_rsp, pred);
      fails++;
    end
    pending_rsps.push_back(has_rsp ? exp_rsp : pred);
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(negedge clk_i);
  endtask

  // response check and stall generation
  always @(posedge clk_i) begin
    rsp_t got, want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = '{status: status_e'(rsp_if.status), proc_id: rsp_if.result_proc,
              empty: rsp_if.queue_empty};
      if (pending_rsps.size() == 0) begin
        $error("response with nothing expected: %p", got);
        fails++;
      end else begin
        want = pending_rsps.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fails++;
        end
        if (got.proc_id != want.proc_id) begin
          $error("result_proc: expected %0d, got %0d", want.proc_id, got.proc_id);
          fails++;
        end
        if (got.empty != want.empty) begin
          $error("queue_empty: expected %0d, got %0d", want.empty, got.empty);
          fails++;
        end
      end
    end
  end

  always @(negedge clk_i)
    rsp_if.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    row_t table_rows[$];
    req_t r;
    int mode;
    req_if.valid = 1'b0;
    req_if.op = OP_INSERT;
    req_if.queue_id = '0;
    req_if.proc_id = '0;
    req_if.priority_req = '0;
    rsp_if.ready = 1'b1;
    for (int i = 0; i < NPROC; i++) begin
      nxt_q[i] = '0; prv_q[i] = '0; prio_q[i] = '0; owner_q[i] = 4'(NQ);
    end
    for (int i = 0; i < NQ; i++) begin
      head_q[i] = NIL; tail_q[i] = NIL;
    end

    table_rows.push_back(mk(OP_QUERY, 0, 0, 0, 1, ST_OK, 0, 1));
    table_rows.push_back(mk(OP_PEEK, 7, 0, 0, 1, ST_MISS, 0, 1));
    table_rows.push_back(mk(OP_REMOVE_HEAD, 3, 0, 0, 1, ST_MISS, 0, 1));
    table_rows.push_back(mk(OP_REMOVE_SLOT, 3, 5, 0, 1, ST_MISS, 0, 1));
    table_rows.push_back(mk(OP_INSERT, 7, 31, 255, 1, ST_OK, 31, 0));
    table_rows.push_back(mk(OP_INSERT, 7, 0, 0, 1, ST_OK, 0, 0));
    table_rows.push_back(mk(OP_INSERT, 7, 10, 255));  // equal prio goes behind
    table_rows.push_back(mk(OP_INSERT, 7, 11, 128));
    table_rows.push_back(mk(OP_INSERT, 0, 31, 7, 1, ST_QUEUED, 0, 1));
    table_rows.push_back(mk(OP_REMOVE_SLOT, 0, 10, 0, 1, ST_MISS, 0, 1));
    table_rows.push_back(mk(OP_PEEK, 7, 0, 0, 1, ST_OK, 31, 0));
    table_rows.push_back(mk(OP_RSVD5, 7, 3, 3, 1, ST_OK, 0, 0));
    table_rows.push_back(mk(OP_RSVD6, 1, 3, 3, 1, ST_OK, 0, 1));
    table_rows.push_back(mk(OP_RSVD7, 7, 3, 3, 1, ST_OK, 0, 0));
    table_rows.push_back(mk(OP_REMOVE_SLOT, 7, 11, 0));  // middle
    table_rows.push_back(mk(OP_REMOVE_SLOT, 7, 0, 0));   // tail
    table_rows.push_back(mk(OP_REMOVE_HEAD, 7, 0, 0, 1, ST_OK, 31, 0));
    table_rows.push_back(mk(OP_REMOVE_HEAD, 7, 0, 0, 1, ST_OK, 10, 1));
    table_rows.push_back(mk(OP_QUERY, 7, 0, 0, 1, ST_OK, 0, 1));

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (table_rows[i]) send(table_rows[i].req, table_rows[i].has_rsp, table_rows[i].rsp);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? 70 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 70 : 0;
      if (ph == 3) begin
        send_idle_pct = 23; recv_stall_pct = 23;
      end
      for (int n = 0; n < 100; n++) begin
        mode = $urandom_range(99);
        r.qid = (ph == 4) ? 3'($urandom_range(1)) : 3'($urandom_range(NQ - 1));
        r.pid = 5'($urandom_range(NPROC - 1));
        // narrow priority range in some items so ties are common
        r.prio = (mode < 20) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        if (mode < 45) r.op = OP_INSERT;
        else if (mode < 65) r.op = OP_REMOVE_HEAD;
        else if (mode < 80) r.op = OP_REMOVE_SLOT;
        else if (mode < 92) r.op = OP_PEEK;
        else r.op = op_e'(3'($urandom_range(4, 7)));
        send(r, 1'b0, '0);
        if (n == 50) drain();  // sender holds until all responses are in
      end
      drain();
    end

    repeat (100) @(negedge clk_i);
    if (fails == 0 && pending_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
